### rtl/core/clnb_pkg.sv
// ----------------------------------------------------------------------------
// clnb_pkg: shared types and constants of the character LCD bus controller
// Item, result, configuration and state records, mode codes and the table of
// command bytes that the power-up sequence sends.
// ----------------------------------------------------------------------------
package clnb_pkg;

  // Request codes carried in the mode field.
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_DATA   = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETTLE     = 3'd0;
  localparam logic [2:0] REG_PULSE      = 3'd1;
  localparam logic [2:0] REG_POWER_WAIT = 3'd2;
  localparam logic [2:0] REG_INIT_GAP   = 3'd3;
  localparam logic [2:0] REG_MOVE_WAIT  = 3'd4;

  // Reset values of the timing registers, in microseconds.
  localparam logic [7:0]  SETTLE_RST     = 8'd20;
  localparam logic [7:0]  PULSE_RST      = 8'd20;
  localparam logic [15:0] POWER_WAIT_RST = 16'd50000;
  localparam logic [15:0] INIT_GAP_RST   = 16'd15000;
  localparam logic [7:0]  MOVE_WAIT_RST  = 8'd50;

  // Phase counter: the longest request, init, has seventeen phases.
  localparam int unsigned  PHASE_W         = 5;
  localparam logic [4:0]   INIT_LAST_PHASE = 5'd16;
  localparam logic [4:0]   INIT_BYTE_BASE  = 5'd5;
  localparam logic [3:0]   INIT_NIB_FUNC   = 4'h2;

  typedef struct packed {
    logic [7:0]  settle_us;
    logic [7:0]  pulse_us;
    logic [15:0] power_wait_us;
    logic [15:0] init_gap_us;
    logic [7:0]  move_wait_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [5:0] column;
    logic       row;
    logic       busy_req;
  } item_t;

  typedef struct packed {
    logic       awaiting_sample;
    logic [7:0] pending_byte;
    logic       pending_is_data;
    logic       pending_move_wait;
    logic [3:0] held_nibble;
  } state_t;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic        drive;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic        await_busy;
    logic [15:0] wait_us;
    logic        last;
  } result_t;

  // Command bytes of the power-up sequence after the function-set nibbles.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0, 3'd1: b = 8'h28;
      3'd2, 3'd3: b = 8'h0C;
      3'd4:       b = 8'h01;
      3'd5:       b = 8'h06;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/clnb_regs.sv
// ----------------------------------------------------------------------------
// clnb_regs: timing registers of the character LCD bus controller
// APB-style register file holding the five bus timing values.
// ----------------------------------------------------------------------------
module clnb_regs
  import clnb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_us     <= SETTLE_RST;
      cfg_r.pulse_us      <= PULSE_RST;
      cfg_r.power_wait_us <= POWER_WAIT_RST;
      cfg_r.init_gap_us   <= INIT_GAP_RST;
      cfg_r.move_wait_us  <= MOVE_WAIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETTLE:     cfg_r.settle_us     <= pwdata[7:0];
        REG_PULSE:      cfg_r.pulse_us      <= pwdata[7:0];
        REG_POWER_WAIT: cfg_r.power_wait_us <= pwdata[15:0];
        REG_INIT_GAP:   cfg_r.init_gap_us   <= pwdata[15:0];
        REG_MOVE_WAIT:  cfg_r.move_wait_us  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETTLE:     prdata = {24'd0, cfg_r.settle_us};
      REG_PULSE:      prdata = {24'd0, cfg_r.pulse_us};
      REG_POWER_WAIT: prdata = {16'd0, cfg_r.power_wait_us};
      REG_INIT_GAP:   prdata = {16'd0, cfg_r.init_gap_us};
      REG_MOVE_WAIT:  prdata = {24'd0, cfg_r.move_wait_us};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/clnb_phase_gen.sv
// ----------------------------------------------------------------------------
// clnb_phase_gen: bus phase decoder of the character LCD bus controller
// Works out one bus phase from the held request, its phase index, the
// controller state and the timing registers; flags requests to be dropped.
// ----------------------------------------------------------------------------
module clnb_phase_gen
  import clnb_pkg::*;
(
  input  item_t              item,
  input  logic [PHASE_W-1:0] phase,
  input  state_t             state,
  input  cfg_t               cfg,
  output result_t            res,
  output logic               drop
);

  function automatic logic [15:0] sat16(input logic [7:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {9'd0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  logic [4:0]  init_off;
  logic [7:0]  init_b;
  logic [2:0]  step;
  logic [15:0] lo_extra;

  always_comb begin
    init_off = phase - INIT_BYTE_BASE;
    init_b   = init_byte(init_off[3:1]);
    // Command writes skip the two RS framing phases of a data write.
    step     = phase[2:0];
    if (!state.pending_is_data && phase[2:0] >= 3'd2) begin
      step = phase[2:0] + 3'd1;
    end
    lo_extra = state.pending_move_wait ? {8'd0, cfg.move_wait_us} : 16'd0;

    res            = '0;
    res.nibble     = state.held_nibble;
    drop           = 1'b0;

    unique case (item.mode)
      MODE_INIT: begin
        drop      = state.awaiting_sample;
        res.drive = 1'b1;
        res.last  = (phase == INIT_LAST_PHASE);
        priority if (phase == '0) begin
          res.nibble  = 4'h0;
          res.wait_us = cfg.power_wait_us;
        end else if (phase < 5'd4) begin
          res.nibble     = 4'h0;
          res.strobe_res = 1'b1;
          res.wait_us    = {8'd0, cfg.pulse_us};
        end else if (phase == 5'd4) begin
          res.nibble     = INIT_NIB_FUNC;
          res.strobe_res = 1'b1;
          res.wait_us    = sat16(cfg.pulse_us, cfg.init_gap_us);
        end else begin
          res.strobe_res = 1'b1;
          if (!init_off[0]) begin
            res.nibble  = init_b[7:4];
            res.wait_us = {8'd0, cfg.pulse_us};
          end else begin
            res.nibble  = init_b[3:0];
            res.wait_us = sat16(cfg.pulse_us, cfg.init_gap_us);
          end
        end
      end
      MODE_CMD, MODE_DATA, MODE_MOVE: begin
        // Settle with RW high, then the first read strobe of the busy poll.
        drop           = state.awaiting_sample;
        res.rw         = 1'b1;
        res.strobe_res = phase[0];
        res.await_busy = phase[0];
        res.last       = phase[0];
        res.wait_us    = phase[0] ? {8'd0, cfg.pulse_us} : {8'd0, cfg.settle_us};
      end
      MODE_SAMPLE: begin
        drop = !state.awaiting_sample;
        if (item.busy_req) begin
          res.rw         = 1'b1;
          res.strobe_res = 1'b1;
          res.await_busy = phase[0];
          res.last       = phase[0];
          res.wait_us    = {8'd0, cfg.pulse_us};
        end else begin
          unique case (step)
            3'd0: begin
              res.rw         = 1'b1;
              res.strobe_res = 1'b1;
              res.wait_us    = {8'd0, cfg.pulse_us};
            end
            3'd1: begin
              res.drive   = 1'b1;
              res.wait_us = {8'd0, cfg.settle_us};
            end
            3'd2: begin
              res.rs      = 1'b1;
              res.drive   = 1'b1;
              res.wait_us = {8'd0, cfg.settle_us};
            end
            3'd3: begin
              res.rs         = state.pending_is_data;
              res.drive      = 1'b1;
              res.nibble     = state.pending_byte[7:4];
              res.strobe_res = 1'b1;
              res.wait_us    = {8'd0, cfg.pulse_us};
            end
            3'd4: begin
              res.rs         = state.pending_is_data;
              res.drive      = 1'b1;
              res.nibble     = state.pending_byte[3:0];
              res.strobe_res = 1'b1;
              res.wait_us    = sat16(cfg.pulse_us, lo_extra);
              res.last       = !state.pending_is_data;
            end
            default: begin
              res.drive   = 1'b1;
              res.wait_us = {8'd0, cfg.settle_us};
              res.last    = 1'b1;
            end
          endcase
        end
      end
      default: drop = 1'b1;
    endcase
  end

endmodule

### rtl/core/char_lcd_nibble_bus_controller_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_controller_unit: character LCD 4-bit bus controller
// Turns init, command, data, cursor-move and busy-sample requests into a
// stream of bus phases for an HD44780-style display on a 4-bit bus.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   in_*      input      in_valid / in_ready    one request (mode and operands)
//   out_*     output     out_valid / out_ready  one bus phase per transfer
//   cfg_*     input      APB-style, pready = 1  five timing registers
//
// A request yields one bus phase per cycle while the output side takes them:
// two phases for command, data, cursor-move and busy-sample-while-busy
// requests, four or six for a sample that finds the display free, seventeen
// for init. A request that is dropped is cleared from the request register
// without emitting a phase. The next request is taken in the cycle in which
// the last phase of the current one enters the output register, so the phase
// sequencer stays busy. Reset is synchronous and clears the control state and
// the timing registers to their power-up values. A stall on out_ready freezes
// the phase counter with the pending phase held in the output register.
//
module char_lcd_nibble_bus_controller_unit
  import clnb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  input  logic        in_busy_req,
  // Bus phase channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_rs,
  output logic        out_rw,
  output logic        out_drive,
  output logic [3:0]  out_nibble,
  output logic        out_strobe_res,
  output logic        out_await_busy,
  output logic [15:0] out_wait_us,
  output logic        out_last,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t               cfg;
  item_t              item_r;
  logic               item_valid_r;
  logic [PHASE_W-1:0] phase_r;
  state_t             state_r;
  result_t            res;
  result_t            out_r;
  logic               out_valid_r;
  logic               drop;
  logic               advance;
  logic               emit;
  logic               item_done;
  logic               in_take;

  clnb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  clnb_phase_gen u_phase_gen (
    .item  (item_r),
    .phase (phase_r),
    .state (state_r),
    .cfg   (cfg),
    .res   (res),
    .drop  (drop)
  );

  // The output register can take a new phase when it is empty or being read.
  assign advance   = !out_valid_r || out_ready;
  assign emit      = item_valid_r && !drop && advance;
  // The held request is finished when it is dropped or its last phase is emitted.
  assign item_done = item_valid_r && (drop || (advance && res.last));
  assign in_ready  = !item_valid_r || item_done;
  assign in_take   = in_valid && in_ready;

  // Request register and phase counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      phase_r      <= '0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (item_done) begin
        item_valid_r <= 1'b0;
      end
      if (item_done) begin
        phase_r <= '0;
      end else if (emit) begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode     <= in_mode;
      item_r.value    <= in_value;
      item_r.column   <= in_column;
      item_r.row      <= in_row;
      item_r.busy_req <= in_busy_req;
    end
  end

  // Controller state: the data latch follows every emitted phase, the poll
  // bookkeeping changes when a request's last phase is emitted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (emit) begin
      state_r.held_nibble <= res.nibble;
      if (res.last) begin
        if (item_r.mode == MODE_SAMPLE) begin
          if (!item_r.busy_req) begin
            state_r.awaiting_sample <= 1'b0;
          end
        end else if (item_r.mode != MODE_INIT) begin
          state_r.awaiting_sample   <= 1'b1;
          state_r.pending_is_data   <= (item_r.mode == MODE_DATA);
          state_r.pending_move_wait <= (item_r.mode == MODE_MOVE);
          if (item_r.mode == MODE_MOVE) begin
            state_r.pending_byte <= {1'b1, item_r.row, item_r.column};
          end else begin
            state_r.pending_byte <= item_r.value;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rs         = out_r.rs;
  assign out_rw         = out_r.rw;
  assign out_drive      = out_r.drive;
  assign out_nibble     = out_r.nibble;
  assign out_strobe_res = out_r.strobe_res;
  assign out_await_busy = out_r.await_busy;
  assign out_wait_us    = out_r.wait_us;
  assign out_last       = out_r.last;

endmodule
